>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with an asynchronous active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Types, register indexes and arithmetic helpers for the barometric
// temperature and pressure compensation unit.
// ----------------------------------------------------------------------------
package bptc_pkg;

	typedef enum logic [1:0] {
		CFG_TEMP_CAL  = 2'd0,
		CFG_PRES_CAL_A = 2'd1,
		CFG_PRES_CAL_B = 2'd2,
		CFG_PRES_CAL_C = 2'd3
	} cfg_index_t;

	localparam int unsigned CfgDataW = 64;
	localparam int unsigned DivStages = 32;

	localparam logic [31:0] FineOffset = 32'd64000;
	localparam logic [31:0] PresBase = 32'd1048576;
	localparam logic [31:0] PresScale = 32'd3125;
	localparam logic [31:0] DivHalf = 32'h8000_0000;
	localparam logic [31:0] P1Offset = 32'd32768;
	localparam logic [31:0] TempRound = 32'd128;

	typedef struct packed {
		logic [19:0] pressure_raw;
		logic [19:0] temperature_raw;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] fine_temperature;
		logic [31:0]        pressure_pa;
		logic               pressure_invalid;
	} out_t;

	// Values that ride alongside the divider.
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic        invalid;
		logic        dbl;
	} side_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'b0, a} * {32'b0, b};
		return p[31:0];
	endfunction

endpackage

>>> hw/rtl/baro_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; the whole pipeline advances together
// and freezes only while a finished result is held by the downstream stall.
// The 32-stage restoring divider sets the depth. Reset clears all valid bits
// and the calibration registers to zero.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// 32-bit integer temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bptc_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bptc_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [bptc_pkg::CfgDataW-1:0] cfg_wdata
);
	import bptc_pkg::*;

	logic [47:0] temp_cal_q;
	logic [63:0] pres_a_q, pres_b_q;
	logic [15:0] pres_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			pres_a_q <= '0;
			pres_b_q <= '0;
			pres_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_TEMP_CAL: temp_cal_q <= cfg_wdata[47:0];
				CFG_PRES_CAL_A: pres_a_q <= cfg_wdata;
				CFG_PRES_CAL_B: pres_b_q <= cfg_wdata;
				CFG_PRES_CAL_C: pres_c_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'b0, temp_cal_q[15:0]};
	assign t2 = sx16(temp_cal_q[31:16]);
	assign t3 = sx16(temp_cal_q[47:32]);
	assign p1 = {16'b0, pres_a_q[15:0]};
	assign p2 = sx16(pres_a_q[31:16]);
	assign p3 = sx16(pres_a_q[47:32]);
	assign p4 = sx16(pres_a_q[63:48]);
	assign p5 = sx16(pres_b_q[15:0]);
	assign p6 = sx16(pres_b_q[31:16]);
	assign p7 = sx16(pres_b_q[47:32]);
	assign p8 = sx16(pres_b_q[63:48]);
	assign p9 = sx16(pres_c_q);

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s43, v_s44, v_s45, v_s46;
	logic div_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			{v_s43, v_s44, v_s45, v_s46} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s43 <= div_v;
			v_s44 <= v_s43;
			v_s45 <= v_s44;
			v_s46 <= v_s45;
		end
	end

	logic [31:0] adc_t, adc_p, d_t;
	assign adc_t = {12'b0, in_data.temperature_raw};
	assign adc_p = {12'b0, in_data.pressure_raw};
	assign d_t = (adc_t >> 4) - t1;

	logic [31:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic [31:0] m1_s1, sqd_s1, a_s2, bm_s2, fine_s3;
	logic [31:0] tm_s4, pa_s4, fine_s4;
	logic [31:0] temp_s5, fine_s5, sq_s5, ap5_s5, ap2_s5;
	logic [31:0] temp_s6, fine_s6, b1_s6, m3_s6, ap5_s6, ap2_s6;
	logic [31:0] temp_s7, fine_s7, b_s7, a_s7;
	logic [31:0] temp_s8, fine_s8, am_s8, b12_s8, adcp_s8;
	logic [31:0] temp_s9, fine_s9, div_s9, num_s9;
	logic [31:0] temp_s10, fine_s10, div_s10, pm_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			adcp_s1 <= adc_p;
			m1_s1 <= mul32((adc_t >> 3) - (t1 << 1), t2);
			sqd_s1 <= mul32(d_t, d_t);

			adcp_s2 <= adcp_s1;
			a_s2 <= asr(m1_s1, 5'd11);
			bm_s2 <= mul32(asr(sqd_s1, 5'd12), t3);

			adcp_s3 <= adcp_s2;
			fine_s3 <= a_s2 + asr(bm_s2, 5'd14);

			adcp_s4 <= adcp_s3;
			fine_s4 <= fine_s3;
			tm_s4 <= mul32(fine_s3, 32'd5) + TempRound;
			pa_s4 <= asr(fine_s3, 5'd1) - FineOffset;

			adcp_s5 <= adcp_s4;
			fine_s5 <= fine_s4;
			temp_s5 <= asr(tm_s4, 5'd8);
			sq_s5 <= mul32(asr(pa_s4, 5'd2), asr(pa_s4, 5'd2));
			ap5_s5 <= mul32(pa_s4, p5);
			ap2_s5 <= mul32(p2, pa_s4);

			adcp_s6 <= adcp_s5;
			fine_s6 <= fine_s5;
			temp_s6 <= temp_s5;
			b1_s6 <= mul32(asr(sq_s5, 5'd11), p6);
			m3_s6 <= mul32(p3, asr(sq_s5, 5'd13));
			ap5_s6 <= ap5_s5;
			ap2_s6 <= ap2_s5;

			adcp_s7 <= adcp_s6;
			fine_s7 <= fine_s6;
			temp_s7 <= temp_s6;
			b_s7 <= asr(b1_s6 + (ap5_s6 << 1), 5'd2) + (p4 << 16);
			a_s7 <= asr(asr(m3_s6, 5'd3) + asr(ap2_s6, 5'd1), 5'd18);

			adcp_s8 <= adcp_s7;
			fine_s8 <= fine_s7;
			temp_s8 <= temp_s7;
			am_s8 <= mul32(P1Offset + a_s7, p1);
			b12_s8 <= asr(b_s7, 5'd12);

			fine_s9 <= fine_s8;
			temp_s9 <= temp_s8;
			div_s9 <= asr(am_s8, 5'd15);
			num_s9 <= (PresBase - adcp_s8) - b12_s8;

			fine_s10 <= fine_s9;
			temp_s10 <= temp_s9;
			div_s10 <= div_s9;
			pm_s10 <= mul32(num_s9, PresScale);
		end
	end

	// Dividends with the top bit set are divided unshifted and the quotient
	// doubled afterward, as the fixed-point scheme does.
	side_t side_in, side_out;
	logic  dbl;
	logic [31:0] dividend, quotient;
	assign dbl = (pm_s10 >= DivHalf);
	assign dividend = dbl ? pm_s10 : (pm_s10 << 1);
	assign side_in = '{temp: temp_s10, fine: fine_s10, invalid: (div_s10 == '0), dbl: dbl};

	bptc_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s10),
		.dividend(dividend),
		.divisor(div_s10),
		.side_in(side_in),
		.out_valid(div_v),
		.quotient(quotient),
		.side_out(side_out)
	);

	side_t side_s43, side_s44, side_s45, side_s46;
	logic [31:0] pres_s43, pres_s44, pres_s45, pres_s46;
	logic [31:0] sqp_s44, bp_s44, ap_s45, bp_s45;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s43 <= side_out;
			pres_s43 <= side_out.dbl ? (quotient << 1) : quotient;

			side_s44 <= side_s43;
			pres_s44 <= pres_s43;
			sqp_s44 <= mul32(pres_s43 >> 3, pres_s43 >> 3) >> 13;
			bp_s44 <= mul32(pres_s43 >> 2, p8);

			side_s45 <= side_s44;
			pres_s45 <= pres_s44;
			ap_s45 <= asr(mul32(p9, sqp_s44), 5'd12);
			bp_s45 <= asr(bp_s44, 5'd13);

			side_s46 <= side_s45;
			pres_s46 <= side_s45.invalid ? '0
				: pres_s45 + asr(ap_s45 + bp_s45 + p7, 5'd4);
		end
	end

	assign out_valid = v_s46;
	assign out_data.temperature_centi = side_s46.temp;
	assign out_data.fine_temperature = side_s46.fine;
	assign out_data.pressure_pa = pres_s46;
	assign out_data.pressure_invalid = side_s46.invalid;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_inv_zero, clk, arst_n,
		out_valid && out_data.pressure_invalid && (out_data.pressure_pa != '0),
		"flagged pressure is not zero")
	`ASSERT_CLK(a_hold_out, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(out_data),
		"stalled result changed")
	`ASSERT_CLK(a_back_press, clk, arst_n,
		in_stall |-> out_valid && out_stall,
		"input stalled without downstream stall")

endmodule

>>> hw/rtl/bptc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_divider
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage,
// with a side payload that travels in step with each operand pair.
// ----------------------------------------------------------------------------
module bptc_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         dividend,
	input  logic [31:0]         divisor,
	input  bptc_pkg::side_t     side_in,
	output logic                out_valid,
	output logic [31:0]         quotient,
	output bptc_pkg::side_t     side_out
);
	import bptc_pkg::*;

	logic        v_s   [1:DivStages];
	logic [31:0] rem_s [1:DivStages];
	logic [31:0] num_s [1:DivStages];
	logic [31:0] quo_s [1:DivStages];
	logic [31:0] den_s [1:DivStages];
	side_t       side_s[1:DivStages];

	genvar k;
	generate
		for (k = 0; k < DivStages; k++) begin : g_stage
			logic        v_in;
			logic [31:0] rem_in, num_in, quo_in, den_in;
			side_t       side_v;
			logic [32:0] trial;
			logic [32:0] diff;
			logic        qbit;

			if (k == 0) begin : g_first
				assign v_in = in_valid;
				assign rem_in = '0;
				assign num_in = dividend;
				assign quo_in = '0;
				assign den_in = divisor;
				assign side_v = side_in;
			end else begin : g_next
				assign v_in = v_s[k];
				assign rem_in = rem_s[k];
				assign num_in = num_s[k];
				assign quo_in = quo_s[k];
				assign den_in = den_s[k];
				assign side_v = side_s[k];
			end

			assign trial = {rem_in, num_in[31]};
			assign diff = trial - {1'b0, den_in};
			assign qbit = !diff[32];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k+1] <= 1'b0;
				end else if (en) begin
					v_s[k+1] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= qbit ? diff[31:0] : trial[31:0];
					num_s[k+1] <= {num_in[30:0], 1'b0};
					quo_s[k+1] <= {quo_in[30:0], qbit};
					den_s[k+1] <= den_in;
					side_s[k+1] <= side_v;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[DivStages];
	assign quotient = quo_s[DivStages];
	assign side_out = side_s[DivStages];

endmodule
